FILE: rtl/dpf_pkg.sv
// Package for the duplicate packet ID filter: opcodes, match classes and
// the command/status structs between controller and datapath. No dependencies.
package dpf_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_class;

    localparam t_op OP_LOOKUP   = 2'd0;
    localparam t_op OP_REGISTER = 2'd1;
    localparam t_op OP_LOOK_REG = 2'd2;
    localparam t_op OP_UNUSED   = 2'd3;

    localparam t_class CLS_NONE    = 2'd0;
    localparam t_class CLS_EXACT   = 2'd1;
    localparam t_class CLS_PARTIAL = 2'd2;

    typedef struct packed {
        logic clr;   // clear one store entry (and pointer) per cycle
        logic load;  // capture a request
        logic div;   // bucket quotient
        logic bkt;   // bucket remainder
        logic base;  // bucket base address, pointer read
        logic scan;  // issue one scan read
        logic prd;   // read the entry under the ring pointer
        logic wr;    // store the ID, advance the pointer
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_last;
        t_op  op;
        logic exact;
        logic same_cur;
    } t_status;

endpackage

FILE: rtl/duplicate_packet_id_filter.sv
// Top level of the duplicate packet ID filter: controller plus datapath.
// Depends on dpf_pkg, dpf_ctrl and dpf_datapath.
//
// Usage:
//   Request channel: drive i_opcode and the four ID bytes with start high;
//   the request is taken at a clock edge where start is high and busy low.
//   Result channel: o_valid pulses for one cycle with o_match_class and
//   o_was_written; the receiver must take it then, there is no stall.
//   Sequence after accept: divide, bucket, base; lookups then scan the
//   bucket and check it; register reads the entry under the ring pointer
//   and writes unless the ID repeats that entry; lookup then register
//   skips the register step on an exact hit; an unused opcode goes
//   straight to the strobe. busy drops the cycle after the strobe. Lookups
//   scan the bucket one entry per cycle through the single store read port.
//   Reset: synchronous, active low. After reset the block clears every
//   entry of the ID store and the ring pointers, one entry a cycle, with
//   busy high; requests wait until it ends.
module duplicate_packet_id_filter #(
    parameter int BUCKETS            = 8,
    parameter int ENTRIES_PER_BUCKET = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_id_b0,
    input  logic [7:0] i_id_b1,
    input  logic [7:0] i_id_b2,
    input  logic [7:0] i_id_b3,
    output logic       o_valid,
    output logic [1:0] o_match_class,
    output logic       o_was_written
);

    dpf_pkg::t_cmd    w_cmd;
    dpf_pkg::t_status w_status;

    dpf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_valid  (o_valid)
    );

    dpf_datapath #(
        .BUCKETS            (BUCKETS),
        .ENTRIES_PER_BUCKET (ENTRIES_PER_BUCKET)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_opcode      (i_opcode),
        .i_id_b0       (i_id_b0),
        .i_id_b1       (i_id_b1),
        .i_id_b2       (i_id_b2),
        .i_id_b3       (i_id_b3),
        .o_status      (w_status),
        .o_match_class (o_match_class),
        .o_was_written (o_was_written)
    );

endmodule

FILE: rtl/dpf_datapath.sv
// Datapath of the duplicate packet ID filter: request registers, bucket
// arithmetic, ID store and ring pointer memories, match logic. Uses dpf_pkg.
module dpf_datapath #(
    parameter int BUCKETS            = 8,
    parameter int ENTRIES_PER_BUCKET = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dpf_pkg::t_cmd    i_cmd,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_id_b0,
    input  logic [7:0]       i_id_b1,
    input  logic [7:0]       i_id_b2,
    input  logic [7:0]       i_id_b3,
    output dpf_pkg::t_status o_status,
    output logic [1:0]       o_match_class,
    output logic             o_was_written
);

    localparam int DEPTH  = BUCKETS * ENTRIES_PER_BUCKET;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int PTR_W  = $clog2(ENTRIES_PER_BUCKET);
    // ceil(2^16 / BUCKETS): exact quotient for any 8-bit dividend
    localparam int RECIP  = (65536 + BUCKETS - 1) / BUCKETS;

    logic [31:0]       r_mem [DEPTH];
    logic [PTR_W-1:0]  r_ptr_mem [BUCKETS];

    dpf_pkg::t_op      r_op;
    logic [31:0]       r_id;
    logic [7:0]        r_quot;
    logic [BKT_W-1:0]  r_bucket;
    logic [ADDR_W-1:0] r_base;
    logic [PTR_W-1:0]  r_ptr;
    logic [PTR_W-1:0]  r_k;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [31:0]       r_rdata;
    logic              r_cmp_en;
    logic              r_exact;
    logic              r_part;
    logic              r_wr;

    logic [24:0]       w_qprod;
    logic [16:0]       w_qb;
    logic [16:0]       w_rem;
    logic [PTR_W-1:0]  w_ptr_next;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_wr_addr;

    assign w_qprod    = 25'(r_id[15:8]) * 25'(RECIP);
    assign w_qb       = 17'(r_quot) * 17'(BUCKETS);
    assign w_rem      = {9'd0, r_id[15:8]} - w_qb;
    assign w_ptr_next = (r_ptr == PTR_W'(ENTRIES_PER_BUCKET - 1)) ? '0 : r_ptr + 1'b1;
    assign w_rd_addr  = i_cmd.prd ? r_base + ADDR_W'(r_ptr) : r_base + ADDR_W'(r_k);
    assign w_wr_addr  = r_base + ADDR_W'(w_ptr_next);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr) begin
            r_mem[w_wr_addr] <= r_id;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            if (r_clr_addr < ADDR_W'(BUCKETS)) begin
                r_ptr_mem[r_clr_addr[BKT_W-1:0]] <= '0;
            end
        end else if (i_cmd.wr) begin
            r_ptr_mem[r_bucket] <= w_ptr_next;
        end
        if (i_cmd.base) begin
            r_ptr <= r_ptr_mem[r_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_id <= {i_id_b3, i_id_b2, i_id_b1, i_id_b0};
        end
        if (i_cmd.div) begin
            r_quot <= w_qprod[23:16];
        end
        if (i_cmd.bkt) begin
            r_bucket <= w_rem[BKT_W-1:0];
        end
        if (i_cmd.base) begin
            r_base <= ADDR_W'(r_bucket) * ADDR_W'(ENTRIES_PER_BUCKET);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_k        <= '0;
            r_cmp_en   <= 1'b0;
            r_exact    <= 1'b0;
            r_part     <= 1'b0;
            r_wr       <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.scan;
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_k     <= '0;
                r_exact <= 1'b0;
                r_part  <= 1'b0;
                r_wr    <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_k <= r_k + 1'b1;
                end
                // read data arrives in the cycle after the scan read
                if (r_cmp_en && r_rdata[31:8] == r_id[31:8]) begin
                    if (r_rdata[7:0] == r_id[7:0]) begin
                        r_exact <= 1'b1;
                    end else begin
                        r_part <= 1'b1;
                    end
                end
                if (i_cmd.wr) begin
                    r_wr <= 1'b1;
                end
            end
        end
    end

    assign o_status.clr_last  = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_status.scan_last = (r_k == PTR_W'(ENTRIES_PER_BUCKET - 1));
    assign o_status.op        = r_op;
    assign o_status.exact     = r_exact;
    assign o_status.same_cur  = (r_rdata == r_id);

    assign o_match_class = r_exact ? dpf_pkg::CLS_EXACT :
                           r_part  ? dpf_pkg::CLS_PARTIAL : dpf_pkg::CLS_NONE;
    assign o_was_written = r_wr;

endmodule

FILE: rtl/dpf_ctrl.sv
// Controller of the duplicate packet ID filter: sequences clearing, bucket
// selection, scan and register steps. Uses dpf_pkg.
module dpf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dpf_pkg::t_status i_status,
    output dpf_pkg::t_cmd    o_cmd,
    output logic             o_valid
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_BKT   = 4'd3;
    localparam logic [3:0] S_BASE  = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_PRD   = 4'd8;
    localparam logic [3:0] S_PCMP  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_BKT;
            end
            S_BKT: begin
                o_cmd.bkt = 1'b1;
                n_state   = S_BASE;
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                priority if (i_status.op == dpf_pkg::OP_LOOKUP ||
                             i_status.op == dpf_pkg::OP_LOOK_REG) begin
                    n_state = S_SCAN;
                end else if (i_status.op == dpf_pkg::OP_REGISTER) begin
                    n_state = S_PRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_status.op == dpf_pkg::OP_LOOK_REG && !i_status.exact) begin
                    n_state = S_PRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PRD: begin
                o_cmd.prd = 1'b1;
                n_state   = S_PCMP;
            end
            S_PCMP: begin
                // repeat of the current entry writes nothing
                o_cmd.wr = !i_status.same_cur;
                n_state  = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

FILE: rtl/dpf_checker.sv
// Port-level checks for the duplicate packet ID filter, bound to the top
// level. Uses dpf_pkg.
module dpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [1:0] o_match_class,
    input logic       o_was_written
);

    // reset always starts the clearing pass
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low after accepted request");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // an exact hit never leads to a store write
    a_exact_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_match_class == dpf_pkg::CLS_EXACT |-> !o_was_written)
        else $error("write reported with exact match");

endmodule

bind duplicate_packet_id_filter dpf_checker u_dpf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_match_class (o_match_class),
    .o_was_written (o_was_written)
);
